// ----- src/swbtd_pkg.sv -----
package swbtd_pkg;

  localparam int ANGLE_STEPS_DEF = 11;

  localparam int IDX_W   = 4;
  localparam int DIST_W  = 8;
  localparam int ANGLE_W = 11;
  localparam int KIND_W  = 2;
  localparam int SWP_W   = 4;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = DIST_W + PCT_W;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [KIND_W-1:0] KIND_BG     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PCT    = 2'd2;

  localparam logic [SWP_W-1:0]  SWEEPS_RST = 4'd2;
  localparam logic [DIST_W-1:0] FLOOR_RST  = 8'd30;
  localparam logic [PCT_W-1:0]  PCT_RST    = 7'd80;
  localparam logic [DIST_W-1:0] RANGE_EMPTY = 8'hFF;
  localparam logic [PCT_W-1:0]  HUNDRED    = 7'd100;

  // angle = floor((7 + i) * 900 / 11), stepped as quotient and remainder
  localparam logic [ANGLE_W-1:0] ANG_Q0    = 11'd572;
  localparam logic [3:0]         ANG_R0    = 4'd8;
  localparam logic [ANGLE_W-1:0] ANG_QSTEP = 11'd81;
  localparam logic [3:0]         ANG_RSTEP = 4'd9;
  localparam logic [4:0]         ANG_DIV   = 5'd11;

  localparam logic [ANGLE_W-1:0] ANGLE_LUT [16] = '{
    11'd572,  11'd654,  11'd736,  11'd818,
    11'd900,  11'd981,  11'd1063, 11'd1145,
    11'd1227, 11'd1309, 11'd1390, 11'd1472,
    11'd1554, 11'd1636, 11'd1718, 11'd1800
  };

  typedef struct packed {
    logic take;
    logic commit;
    logic dump_rd;
    logic dump_push;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic cal_done;
    logic dump_last;
    logic out_free;
  } stat_t;

endpackage

// ----- src/swbtd_ctrl.sv -----
module swbtd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tuser,
  output logic                s_tready,
  input  swbtd_pkg::stat_t    st,
  output swbtd_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DUMP_RD,
    ST_DUMP_PUSH
  } state_t;

  state_t state;
  logic   rdy;
  logic   go;

  assign s_tready = rdy;
  assign go = !st.emit || st.out_free;

  always_comb begin
    cmd = '0;
    cmd.take = s_tvalid && rdy;
    unique case (state)
      ST_IDLE:      ;
      ST_EVAL:      cmd.commit = go;
      ST_DUMP_RD:   cmd.dump_rd = 1'b1;
      ST_DUMP_PUSH: cmd.dump_push = st.out_free;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rdy   <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && rdy && !s_tuser) begin
            state <= ST_EVAL;
            rdy   <= 1'b0;
          end
        end
        ST_EVAL: begin
          if (go) begin
            if (st.cal_done) begin
              state <= ST_DUMP_RD;
            end else begin
              state <= ST_IDLE;
              rdy   <= 1'b1;
            end
          end
        end
        ST_DUMP_RD: state <= ST_DUMP_PUSH;
        ST_DUMP_PUSH: begin
          if (st.out_free) begin
            if (st.dump_last) begin
              state <= ST_IDLE;
              rdy   <= 1'b1;
            end else begin
              state <= ST_DUMP_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/swbtd_dp.sv -----
module swbtd_dp #(
  parameter int ANGLE_STEPS = swbtd_pkg::ANGLE_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [swbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swbtd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [swbtd_pkg::S_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [swbtd_pkg::M_DATA_W-1:0]       m_tdata,
  output logic [swbtd_pkg::KIND_W-1:0]         m_tuser,
  output logic                                 m_tlast,
  input  swbtd_pkg::cmd_t                      cmd,
  output swbtd_pkg::stat_t                     st
);

  localparam int AW = $clog2(ANGLE_STEPS);

  logic [swbtd_pkg::SWP_W-1:0]  cfg_sweeps;
  logic [swbtd_pkg::DIST_W-1:0] cfg_floor;
  logic [swbtd_pkg::PCT_W-1:0]  cfg_pct;

  logic [swbtd_pkg::DIST_W-1:0] mem [ANGLE_STEPS];
  logic [ANGLE_STEPS-1:0]       bg_valid;
  logic [swbtd_pkg::DIST_W-1:0] rd_data;
  logic                         rd_hit;

  logic [swbtd_pkg::IDX_W-1:0]  in_idx;
  logic [swbtd_pkg::DIST_W-1:0] in_dist;
  logic                         in_end;
  logic [AW-1:0]                in_addr;
  logic [AW-1:0]                s_addr;

  logic [swbtd_pkg::SWP_W-1:0]  sweeps_left;
  logic [swbtd_pkg::DIST_W-1:0] near_dist;
  logic [swbtd_pkg::IDX_W-1:0]  near_idx;

  logic [AW-1:0]                  dump_cnt;
  logic [swbtd_pkg::ANGLE_W-1:0]  ang_q;
  logic [3:0]                     ang_r;
  logic [4:0]                     ang_r_sum;

  logic [swbtd_pkg::DIST_W-1:0] bg;
  logic [swbtd_pkg::PROD_W-1:0] lhs;
  logic [swbtd_pkg::PROD_W-1:0] rhs;
  logic                         calibrating;
  logic                         in_range;
  logic                         above_floor;
  logic                         cal_wr;
  logic                         hit;
  logic [swbtd_pkg::DIST_W-1:0] res_dist;
  logic [swbtd_pkg::IDX_W-1:0]  res_idx;
  logic                         out_free;

  assign s_addr      = AW'(s_tdata[swbtd_pkg::IDX_W-1:0]);
  assign bg          = rd_hit ? rd_data : swbtd_pkg::RANGE_EMPTY;
  assign calibrating = sweeps_left != '0;
  assign in_range    = 32'(in_idx) < 32'(ANGLE_STEPS);
  assign above_floor = in_dist > cfg_floor;
  assign lhs         = swbtd_pkg::PROD_W'(in_dist) * swbtd_pkg::PROD_W'(swbtd_pkg::HUNDRED);
  assign rhs         = swbtd_pkg::PROD_W'(cfg_pct) * swbtd_pkg::PROD_W'(bg);
  assign cal_wr      = calibrating && in_range && above_floor && in_dist < bg;
  assign hit         = !calibrating && in_range && above_floor && lhs < rhs
                       && in_dist < near_dist;
  assign res_dist    = hit ? in_dist : near_dist;
  assign res_idx     = hit ? in_idx : near_idx;
  assign out_free    = !m_tvalid || m_tready;
  assign ang_r_sum   = {1'b0, ang_r} + {1'b0, swbtd_pkg::ANG_RSTEP};

  assign st.emit      = !calibrating && in_end;
  assign st.cal_done  = calibrating && in_end && sweeps_left == 4'd1;
  assign st.dump_last = dump_cnt == AW'(ANGLE_STEPS - 1);
  assign st.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sweeps <= swbtd_pkg::SWEEPS_RST;
      cfg_floor  <= swbtd_pkg::FLOOR_RST;
      cfg_pct    <= swbtd_pkg::PCT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swbtd_pkg::CFG_SWEEPS: cfg_sweeps <= cfg_data[swbtd_pkg::SWP_W-1:0];
        swbtd_pkg::CFG_FLOOR:  cfg_floor  <= cfg_data;
        swbtd_pkg::CFG_PCT:    cfg_pct    <= cfg_data[swbtd_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // background table, single read port
  always_ff @(posedge clk) begin
    if (cmd.commit && cal_wr) begin
      mem[in_addr] <= in_dist;
    end
    if (cmd.take) begin
      rd_data <= mem[s_addr];
    end else if (cmd.dump_rd) begin
      rd_data <= mem[dump_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_valid <= '0;
      rd_hit   <= 1'b0;
    end else begin
      if (cmd.take && s_tuser) begin
        bg_valid <= '0;
      end else if (cmd.commit && cal_wr) begin
        bg_valid[in_addr] <= 1'b1;
      end
      if (cmd.take) begin
        rd_hit <= bg_valid[s_addr];
      end else if (cmd.dump_rd) begin
        rd_hit <= bg_valid[dump_cnt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_idx  <= s_tdata[swbtd_pkg::IDX_W-1:0];
      in_dist <= s_tdata[swbtd_pkg::IDX_W +: swbtd_pkg::DIST_W];
      in_end  <= s_tlast;
      in_addr <= s_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeps_left <= swbtd_pkg::SWEEPS_RST;
      near_dist   <= swbtd_pkg::RANGE_EMPTY;
      near_idx    <= '0;
      dump_cnt    <= '0;
      ang_q       <= swbtd_pkg::ANG_Q0;
      ang_r       <= swbtd_pkg::ANG_R0;
    end else begin
      if (cmd.take && s_tuser) begin
        sweeps_left <= cfg_sweeps;
        near_dist   <= swbtd_pkg::RANGE_EMPTY;
        near_idx    <= '0;
      end else if (cmd.commit) begin
        if (calibrating) begin
          if (in_end) begin
            sweeps_left <= sweeps_left - 4'd1;
            near_dist   <= swbtd_pkg::RANGE_EMPTY;
            near_idx    <= '0;
            dump_cnt    <= '0;
            ang_q       <= swbtd_pkg::ANG_Q0;
            ang_r       <= swbtd_pkg::ANG_R0;
          end
        end else if (in_end) begin
          near_dist <= swbtd_pkg::RANGE_EMPTY;
          near_idx  <= '0;
        end else if (hit) begin
          near_dist <= in_dist;
          near_idx  <= in_idx;
        end
      end else if (cmd.dump_push) begin
        dump_cnt <= dump_cnt + AW'(1);
        if (ang_r_sum >= swbtd_pkg::ANG_DIV) begin
          ang_r <= 4'(ang_r_sum - swbtd_pkg::ANG_DIV);
          ang_q <= ang_q + swbtd_pkg::ANG_QSTEP + 11'd1;
        end else begin
          ang_r <= ang_r_sum[3:0];
          ang_q <= ang_q + swbtd_pkg::ANG_QSTEP;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((cmd.commit && st.emit) || cmd.dump_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_push) begin
      m_tuser <= swbtd_pkg::KIND_BG;
      m_tdata <= {1'b0, ang_q, bg, swbtd_pkg::IDX_W'(dump_cnt)};
      m_tlast <= st.dump_last;
    end else if (cmd.commit && st.emit) begin
      m_tlast <= 1'b1;
      if (res_dist != swbtd_pkg::RANGE_EMPTY) begin
        m_tuser <= swbtd_pkg::KIND_TARGET;
        m_tdata <= {1'b0, swbtd_pkg::ANGLE_LUT[res_idx], res_dist, res_idx};
      end else begin
        m_tuser <= swbtd_pkg::KIND_NONE;
        m_tdata <= '0;
      end
    end
  end

endmodule

// ----- src/sweep_background_target_detector.sv -----
// Sweep background target detector. Distance readings arrive one beat per
// angle step; a restart beat (tuser high) clears the background table to 255
// and reloads the calibration sweep count. A reading first reads its
// background entry from the single-port table, then updates the table or the
// nearest-target record, waiting at a sweep end until the result register is
// free. At the end of the last calibration sweep the whole table is read out,
// each entry read and then pushed once the result register is free, through
// the same read port; the input is held off meanwhile. Each sweep end while
// detecting gives one target or no-target beat. The table resets through
// per-entry valid bits, so no clearing pass is needed. Configuration writes
// are taken at any time but must only be made while the block is idle.
module sweep_background_target_detector #(
  parameter int ANGLE_STEPS = swbtd_pkg::ANGLE_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swbtd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [3:0] angle_index, [11:4] distance, [15:12] zero
  input  logic [swbtd_pkg::S_DATA_W-1:0]       s_tdata,
  // cmd
  input  logic                                 s_tuser,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [3:0] entry_index, [11:4] range_value, [22:12] angle_tenths, [23] zero
  output logic [swbtd_pkg::M_DATA_W-1:0]       m_tdata,
  // kind
  output logic [swbtd_pkg::KIND_W-1:0]         m_tuser,
  output logic                                 m_tlast
);

  swbtd_pkg::cmd_t  cmd;
  swbtd_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  swbtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  swbtd_dp #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_push |-> st.out_free)
    else $error("table beat pushed onto a full result register");

  a_busy_after_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> !s_tready)
    else $error("reading accepted without holding off input");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == swbtd_pkg::KIND_NONE) |-> (m_tdata == '0 && m_tlast))
    else $error("no-target beat carries data");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

  localparam int STEPS       = swbtd_pkg::ANGLE_STEPS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 18;

  localparam logic CMD_READ    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [swbtd_pkg::IDX_W-1:0]  angle;
    logic [swbtd_pkg::DIST_W-1:0] distance;
    logic                         sweep_end;
  } reading_t;

  typedef struct packed {
    logic [swbtd_pkg::KIND_W-1:0]  kind;
    logic [swbtd_pkg::IDX_W-1:0]   angle;
    logic [swbtd_pkg::DIST_W-1:0]  range_val;
    logic [swbtd_pkg::ANGLE_W-1:0] tenths;
    logic                          last;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [swbtd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [swbtd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [swbtd_pkg::S_DATA_W-1:0] s_tdata;
  logic                           s_tuser;
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [swbtd_pkg::M_DATA_W-1:0] m_tdata;
  logic [swbtd_pkg::KIND_W-1:0]   m_tuser;
  logic                           m_tlast;

  reading_t beat_now = '0;
  reading_t pending_readings[$];
  report_t  expected_reports[$];

  // detector state as predicted
  logic [swbtd_pkg::DIST_W-1:0] bg_tab [STEPS];
  logic [swbtd_pkg::SWP_W-1:0]  sweeps_todo;
  logic [swbtd_pkg::DIST_W-1:0] near_dist;
  logic [swbtd_pkg::IDX_W-1:0]  near_angle;
  logic [swbtd_pkg::SWP_W-1:0]  cal_sweeps;
  logic [swbtd_pkg::DIST_W-1:0] floor_dist;
  logic [swbtd_pkg::PCT_W-1:0]  fg_pct;

  int   mismatches = 0;
  int   cycles = 0;
  logic steady = 1'b0;
  logic hold_go = 1'b0;
  logic hold_used;
  int   hold_left = 0;

  sweep_background_target_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  assign s_tdata = {4'b0000, beat_now.distance, beat_now.angle};
  assign s_tuser = beat_now.cmd;
  assign s_tlast = beat_now.sweep_end;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [swbtd_pkg::ANGLE_W-1:0] tenths_of(input int i);
    int t;
    t = (7 + i) * 1800 / 22;
    return t[swbtd_pkg::ANGLE_W-1:0];
  endfunction

  task automatic forget_nearest();
    near_dist  = swbtd_pkg::RANGE_EMPTY;
    near_angle = '0;
  endtask

  task automatic track_reading(input reading_t r);
    report_t e;
    logic    ok;
    int      i;
    ok = (r.angle < STEPS) && (r.distance > floor_dist);
    if (r.cmd == CMD_RESTART) begin
      for (i = 0; i < STEPS; i++) bg_tab[i] = swbtd_pkg::RANGE_EMPTY;
      sweeps_todo = cal_sweeps;
      forget_nearest();
    end else if (sweeps_todo != 0) begin
      if (ok) begin
        if (r.distance < bg_tab[r.angle]) bg_tab[r.angle] = r.distance;
      end
      if (r.sweep_end) begin
        sweeps_todo = sweeps_todo - 1'b1;
        if (sweeps_todo == 0) begin
          for (i = 0; i < STEPS; i++) begin
            e.kind      = swbtd_pkg::KIND_BG;
            e.angle     = i[swbtd_pkg::IDX_W-1:0];
            e.range_val = bg_tab[i];
            e.tenths    = tenths_of(i);
            e.last      = (i == STEPS - 1);
            expected_reports.push_back(e);
          end
        end
        forget_nearest();
      end
    end else begin
      if (ok) begin
        if (int'(r.distance) * 100 < int'(fg_pct) * int'(bg_tab[r.angle]) &&
            r.distance < near_dist) begin
          near_dist  = r.distance;
          near_angle = r.angle;
        end
      end
      if (r.sweep_end) begin
        if (near_dist != swbtd_pkg::RANGE_EMPTY) begin
          e.kind      = swbtd_pkg::KIND_TARGET;
          e.angle     = near_angle;
          e.range_val = near_dist;
          e.tenths    = tenths_of(int'(near_angle));
        end else begin
          e.kind      = swbtd_pkg::KIND_NONE;
          e.angle     = '0;
          e.range_val = '0;
          e.tenths    = '0;
        end
        e.last = 1'b1;
        expected_reports.push_back(e);
        forget_nearest();
      end
    end
  endtask

  task automatic note_mismatch(input string what, input int got_v, input int want_v);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got_v, want_v);
  endtask

  task automatic check_beat();
    report_t want;
    if (expected_reports.size() == 0) begin
      note_mismatch("result beat with nothing pending, kind", m_tuser, -1);
    end else begin
      want = expected_reports.pop_front();
      if (m_tuser != want.kind) note_mismatch("kind", m_tuser, want.kind);
      if (m_tdata[3:0] != want.angle) note_mismatch("entry_index", m_tdata[3:0], want.angle);
      if (m_tdata[11:4] != want.range_val)
        note_mismatch("range_value", m_tdata[11:4], want.range_val);
      if (m_tdata[22:12] != want.tenths)
        note_mismatch("angle_tenths", m_tdata[22:12], want.tenths);
      if (m_tlast != want.last) note_mismatch("last", m_tlast, want.last);
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_reading(beat_now);
      if (!s_tvalid || s_tready) begin
        if (pending_readings.size() != 0 &&
            (steady || $urandom_range(99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          beat_now <= pending_readings.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      m_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // one long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [swbtd_pkg::DIST_W-1:0] pick_dist();
    case ($urandom_range(3))
      0: return swbtd_pkg::DIST_W'($urandom_range(255));
      1: return swbtd_pkg::DIST_W'($urandom_range(15, 110));
      2: return floor_dist + swbtd_pkg::DIST_W'($urandom_range(0, 2));
      default: return $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic add_reading(input int a, input int d, input logic fin);
    reading_t r;
    r.cmd       = CMD_READ;
    r.angle     = a[swbtd_pkg::IDX_W-1:0];
    r.distance  = d[swbtd_pkg::DIST_W-1:0];
    r.sweep_end = fin;
    pending_readings.push_back(r);
  endtask

  task automatic add_restart();
    reading_t r;
    r     = reading_t'($urandom);
    r.cmd = CMD_RESTART;
    pending_readings.push_back(r);
  endtask

  // mostly in-order sweeps with random distances; some restarts and noise
  task automatic add_traffic(input int n, input int max_len);
    reading_t r;
    int       made;
    int       len;
    int       a;
    int       pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        add_restart();
        made++;
      end else if (pick < 12) begin
        r     = reading_t'($urandom);
        r.cmd = CMD_READ;
        pending_readings.push_back(r);
        made++;
      end else begin
        len = ($urandom_range(4) == 0) ? int'($urandom_range(1, max_len)) : max_len;
        for (a = 0; a < len; a++) begin
          r.cmd       = CMD_READ;
          r.angle     = ($urandom_range(19) == 0) ?
                        swbtd_pkg::IDX_W'($urandom_range(STEPS, 15)) :
                        a[swbtd_pkg::IDX_W-1:0];
          r.distance  = pick_dist();
          r.sweep_end = (a == len - 1);
          pending_readings.push_back(r);
          made++;
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_readings.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swbtd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swbtd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      swbtd_pkg::CFG_SWEEPS: cal_sweeps = val[swbtd_pkg::SWP_W-1:0];
      swbtd_pkg::CFG_FLOOR:  floor_dist = val[swbtd_pkg::DIST_W-1:0];
      swbtd_pkg::CFG_PCT:    fg_pct     = val[swbtd_pkg::PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int sweeps, input int flr, input int pct);
    write_reg(swbtd_pkg::CFG_SWEEPS, sweeps[swbtd_pkg::CFG_DATA_W-1:0]);
    write_reg(swbtd_pkg::CFG_FLOOR, flr[swbtd_pkg::CFG_DATA_W-1:0]);
    write_reg(swbtd_pkg::CFG_PCT, pct[swbtd_pkg::CFG_DATA_W-1:0]);
    @(negedge clk);
  endtask

  initial begin
    int k;
    for (k = 0; k < STEPS; k++) bg_tab[k] = swbtd_pkg::RANGE_EMPTY;
    sweeps_todo = swbtd_pkg::SWEEPS_RST;
    cal_sweeps  = swbtd_pkg::SWEEPS_RST;
    floor_dist  = swbtd_pkg::FLOOR_RST;
    fg_pct      = swbtd_pkg::PCT_RST;
    forget_nearest();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: two calibration sweeps, floor 30, 80 percent
    add_reading(0, 255, 1'b0);
    add_reading(10, 0, 1'b0);
    add_reading(15, 100, 1'b0);
    add_reading(5, 30, 1'b0);
    add_reading(5, 31, 1'b0);
    add_reading(3, 200, 1'b1);
    add_reading(1, 120, 1'b0);
    add_reading(10, 150, 1'b0);
    add_reading(7, 90, 1'b1);
    // target at the widest angle, a tie that must not win, an off-range end
    add_reading(10, 100, 1'b0);
    add_reading(3, 100, 1'b0);
    add_reading(0, 254, 1'b0);
    add_reading(1, 96, 1'b0);
    add_reading(12, 5, 1'b1);
    // nothing qualifies
    add_reading(0, 255, 1'b0);
    add_reading(5, 31, 1'b0);
    add_reading(4, 20, 1'b1);
    pending_readings.push_back('{CMD_RESTART, 4'hF, 8'hFF, 1'b1});
    add_reading(2, 255, 1'b1);
    add_reading(6, 40, 1'b1);
    add_reading(6, 39, 1'b1);
    wait_idle();

    set_config(1, 0, 100);
    steady = 1'b1;
    add_restart();
    add_traffic(90, STEPS);
    wait_idle();
    steady = 1'b0;

    set_config(15, 255, 1);
    add_restart();
    add_traffic(70, 3);
    wait_idle();

    // zero sweeps: detection straight after restart
    set_config(0, $urandom_range(0, 60), $urandom_range(50, 100));
    add_restart();
    add_traffic(60, STEPS);
    wait_idle();

    for (k = 0; k < 3; k++) begin
      set_config($urandom_range(1, 3), $urandom_range(0, 80), $urandom_range(40, 100));
      add_restart();
      if (k == 0) hold_go = 1'b1;
      add_traffic(30, STEPS);
      wait_idle();
      add_traffic(30, STEPS);
      wait_idle();
    end

    if (expected_reports.size() != 0)
      note_mismatch("results never seen", expected_reports.size(), 0);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/swbtd_pkg.sv
src/swbtd_ctrl.sv
src/swbtd_dp.sv
src/sweep_background_target_detector.sv
sim/tb_top.sv
